@@ rtl/timer_wheel_admission_budget_core_assert.svh @@
// Assertion macros shared by the timer wheel admission budget RTL.
`ifndef TIMER_WHEEL_ADMISSION_BUDGET_CORE_ASSERT_SVH
`define TIMER_WHEEL_ADMISSION_BUDGET_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define TWAB_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("twab assertion failed");
// Next-cycle implication, disabled during reset.
`define TWAB_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("twab assertion failed");
`else
`define TWAB_ASSERT_IMP(label, clk, rst, a, b)
`define TWAB_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

@@ rtl/twab_pkg.sv @@
// Types and constants of the timer wheel admission budget block.
`timescale 1ns / 1ps
package twab_pkg;

   // Request kinds
   localparam logic [1:0] REQ_RESERVE = 2'd0;
   localparam logic [1:0] REQ_FILL    = 2'd1;
   localparam logic [1:0] REQ_QUERY   = 2'd2;
   localparam logic [1:0] REQ_CLEAR   = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_LIVE_BUDGET = 2'd0;
   localparam logic [1:0] CSR_FILL_ENABLE = 2'd1;
   localparam logic [1:0] CSR_BUCKET_MS   = 2'd2;
   localparam logic [1:0] CSR_REPORT_MS   = 2'd3;

   localparam int CNT_W = 17;
   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
      logic [31:0] duration_ms;
      logic [31:0] frame_number;
      logic        engine_present;
      logic [16:0] engine_count;
   } twab_req_type;

   typedef struct packed {
      logic        accepted;
      logic [16:0] live_count;
      logic        report_due;
      logic [31:0] dropped_count;
   } twab_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADV,
      S_WALK_RD,
      S_WALK_WR,
      S_CLEAR,
      S_SYNC,
      S_DECIDE,
      S_DIV,
      S_BUMP_RD,
      S_BUMP_WR,
      S_RESP
   } twab_state_type;

endpackage

@@ rtl/twab_ram.sv @@
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module twab_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/timer_wheel_admission_budget_core.sv @@
// Top level of the timer wheel admission budget block.
`timescale 1ns / 1ps
//
// Admission control on a timer wheel. A request comes in on req_valid /
// req_ready with a twab_req_type payload; exactly one result leaves on
// rsp_valid / rsp_ready for each request. Registers are to be written on
// the csr_we / csr_index / csr_wdata port only while the block is idle;
// the block itself does not enforce this. One request is worked at a time;
// req_ready is low until its result has been taken. A query steps the wheel
// over the buckets it has passed, reading and then emptying each one; a
// reservation adds sync and decision, the bit-serial duration divider and a
// bucket update that reads and then writes the bucket.
// A wheel clear (clear request, stale wheel, rewound clock or jump past the
// horizon) sweeps the wheel RAM one entry a cycle.
// After reset the same sweep runs before the first request is taken;
// register writes are taken meanwhile.
// When the receiver stalls, the result holds in its register and no new
// request is taken until it is accepted.
//
module timer_wheel_admission_budget_core #(
   parameter int WHEEL_BUCKETS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  twab_pkg::twab_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output twab_pkg::twab_rsp_type rsp_payload,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import twab_pkg::*;
`include "timer_wheel_admission_budget_core_assert.svh"

   localparam int HW = $clog2(WHEEL_BUCKETS);
   localparam int WBW = $clog2(WHEEL_BUCKETS + 1);
   localparam logic [HW-1:0] LAST_BUCKET = HW'(WHEEL_BUCKETS - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Configuration registers
   logic [15:0] budget_ff;
   logic        fill_en_ff;
   logic [15:0] bucket_ms_ff;
   logic [31:0] report_ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= 16'd4000;
         fill_en_ff   <= 1'b0;
         bucket_ms_ff <= 16'd100;
         report_ms_ff <= 32'd5000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIVE_BUDGET: budget_ff    <= csr_wdata[15:0];
            CSR_FILL_ENABLE: fill_en_ff   <= csr_wdata[0];
            CSR_BUCKET_MS:   bucket_ms_ff <= csr_wdata[15:0];
            CSR_REPORT_MS:   report_ms_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // State registers
   twab_state_type state_ff, state_in, ret_ff, ret_in;
   twab_req_type   req_ff, req_in;
   logic [CNT_W-1:0] live_ff, live_in;
   logic [HW-1:0]  head_ff, head_in, clr_ff, clr_in, idx_ff, idx_in;
   logic [31:0]    head_time_ff, head_time_in;
   logic [31:0]    dropped_ff, dropped_in;
   logic [31:0]    next_rep_ff, next_rep_in;
   logic [31:0]    last_frame_ff, last_frame_in;
   logic           seen_ff, seen_in, stale_ff, stale_in;
   logic           acc_ff, acc_in, rep_ff, rep_in;
   logic [31:0]    drop_out_ff, drop_out_in;
   logic [31:0]    quo_ff, quo_in;
   logic [16:0]    rem_ff, rem_in;
   logic [4:0]     div_cnt_ff, div_cnt_in;

   // Wheel RAM port
   logic             ram_we;
   logic [HW-1:0]    ram_waddr, ram_raddr;
   logic [CNT_W-1:0] ram_wdata, ram_rdata;

   twab_ram #(.WIDTH(CNT_W), .DEPTH(WHEEL_BUCKETS)) u_wheel (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared arithmetic terms
   logic [15:0]     len;
   logic [31:0]     elapsed;
   logic [16+WBW-1:0] horizon;
   logic [HW-1:0]   head_next;
   logic [16:0]     rem_shift;
   logic [16:0]     cap;
   logic [16:0]     actual;
   logic [32:0]     rep_sum;
   logic [31:0]     dropped_inc;
   logic [HW-1:0]   n_off;
   logic [HW:0]     idx_sum;
   logic            is_query;

   assign len       = (bucket_ms_ff == 16'd0) ? 16'd1 : bucket_ms_ff;
   assign elapsed   = req_ff.now_ms - head_time_ff;
   assign horizon   = (16+WBW)'(len) * (16+WBW)'(WHEEL_BUCKETS);
   assign head_next = (head_ff == LAST_BUCKET) ? '0 : head_ff + HW'(1);
   assign rem_shift = {rem_ff[15:0], quo_ff[31]};
   assign cap       = {1'b0, budget_ff} + 17'd1;
   assign actual    = (req_ff.engine_count > cap) ? cap : req_ff.engine_count;
   assign rep_sum   = {1'b0, req_ff.now_ms} + {1'b0, report_ms_ff};
   assign dropped_inc = (dropped_ff == 32'hFFFF_FFFF) ? dropped_ff : dropped_ff + 32'd1;
   // An all-ones quotient wraps the 32-bit offset to zero, which clips to one
   assign n_off     = (quo_ff == 32'hFFFF_FFFF) ? HW'(1) :
                      (quo_ff >= 32'(WHEEL_BUCKETS - 2)) ? LAST_BUCKET
                                                         : quo_ff[HW-1:0] + HW'(1);
   assign idx_sum   = {1'b0, head_ff} + {1'b0, n_off};
   assign is_query  = (req_ff.req_type == REQ_QUERY);

   // Register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ret_ff        <= S_IDLE;
         clr_ff        <= '0;
         live_ff       <= '0;
         head_ff       <= '0;
         head_time_ff  <= '0;
         dropped_ff    <= '0;
         next_rep_ff   <= '0;
         last_frame_ff <= '0;
         seen_ff       <= 1'b0;
         stale_ff      <= 1'b1;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         clr_ff        <= clr_in;
         live_ff       <= live_in;
         head_ff       <= head_in;
         head_time_ff  <= head_time_in;
         dropped_ff    <= dropped_in;
         next_rep_ff   <= next_rep_in;
         last_frame_ff <= last_frame_in;
         seen_ff       <= seen_in;
         stale_ff      <= stale_in;
      end
      req_ff      <= req_in;
      acc_ff      <= acc_in;
      rep_ff      <= rep_in;
      drop_out_ff <= drop_out_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      idx_ff      <= idx_in;
   end

   // Sequencer: next state and datapath
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      live_in       = live_ff;
      head_in       = head_ff;
      head_time_in  = head_time_ff;
      dropped_in    = dropped_ff;
      next_rep_in   = next_rep_ff;
      last_frame_in = last_frame_ff;
      seen_in       = seen_ff;
      stale_in      = stale_ff;
      acc_in        = acc_ff;
      rep_in        = rep_ff;
      drop_out_in   = drop_out_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      idx_in        = idx_ff;
      ram_we        = 1'b0;
      ram_waddr     = head_ff;
      ram_wdata     = '0;
      ram_raddr     = head_next;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            acc_in      = 1'b1;
            rep_in      = 1'b0;
            drop_out_in = '0;
            if (req_ff.req_type == REQ_QUERY) begin
               state_in = S_ADV;
            end else if (req_ff.req_type == REQ_CLEAR) begin
               live_in      = '0;
               head_in      = '0;
               dropped_in   = '0;
               head_time_in = req_ff.now_ms;
               stale_in     = 1'b0;
               clr_in       = '0;
               ret_in       = S_RESP;
               state_in     = S_CLEAR;
            end else if (req_ff.req_type == REQ_FILL && !fill_en_ff) begin
               acc_in   = 1'b0;
               state_in = S_RESP;
            end else if (budget_ff == 16'd0) begin
               stale_in = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            // Clear the wheel when it cannot be walked
            if (stale_ff || req_ff.now_ms < head_time_ff ||
                {{(16+WBW){1'b0}}, elapsed} > {32'd0, horizon}) begin
               live_in      = '0;
               head_in      = '0;
               dropped_in   = '0;
               head_time_in = req_ff.now_ms;
               stale_in     = 1'b0;
               clr_in       = '0;
               ret_in       = is_query ? S_RESP : S_SYNC;
               state_in     = S_CLEAR;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            // Step to the next bucket and fetch its count
            if (elapsed >= {16'd0, len}) begin
               head_time_in = head_time_ff + {16'd0, len};
               head_in      = head_next;
               ram_raddr    = head_next;
               state_in     = S_WALK_WR;
            end else begin
               state_in = is_query ? S_RESP : S_SYNC;
            end
         end
         S_WALK_WR: begin
            // Drop expired items and empty the bucket
            live_in   = (live_ff > ram_rdata) ? live_ff - ram_rdata : '0;
            ram_we    = 1'b1;
            ram_waddr = head_ff;
            ram_wdata = '0;
            state_in  = S_WALK_RD;
         end
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + HW'(1);
            if (clr_ff == LAST_BUCKET) begin
               state_in = ret_ff;
            end
         end
         S_SYNC: begin
            // Raise live count to the external count once per frame
            if (req_ff.engine_present &&
                (!seen_ff || last_frame_ff != req_ff.frame_number)) begin
               seen_in       = 1'b1;
               last_frame_in = req_ff.frame_number;
               if (actual > live_ff) begin
                  live_in = actual;
               end
            end
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (live_ff >= {1'b0, budget_ff}) begin
               acc_in     = 1'b0;
               dropped_in = dropped_inc;
               if (req_ff.now_ms >= next_rep_ff) begin
                  next_rep_in = rep_sum[32] ? 32'hFFFF_FFFF : rep_sum[31:0];
                  rep_in      = 1'b1;
                  drop_out_in = dropped_inc;
                  dropped_in  = '0;
               end
               state_in = S_RESP;
            end else begin
               quo_in     = req_ff.duration_ms;
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            // One quotient bit per cycle
            if (rem_shift >= {1'b0, len}) begin
               rem_in = rem_shift - {1'b0, len};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = S_BUMP_RD;
            end
         end
         S_BUMP_RD: begin
            idx_in    = (idx_sum >= (HW+1)'(WHEEL_BUCKETS))
                        ? HW'(idx_sum - (HW+1)'(WHEEL_BUCKETS)) : idx_sum[HW-1:0];
            ram_raddr = idx_in;
            state_in  = S_BUMP_WR;
         end
         S_BUMP_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);
            if (live_ff != CNT_MAX) begin
               live_in = live_ff + CNT_W'(1);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_payload.accepted      = acc_ff;
   assign rsp_payload.live_count    = live_ff;
   assign rsp_payload.report_due    = rep_ff;
   assign rsp_payload.dropped_count = drop_out_ff;

   // Checks
   `TWAB_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `TWAB_ASSERT_IMP(a_report_is_refusal, clock, reset, rsp_valid && rep_ff, !acc_ff)
   `TWAB_ASSERT_IMP(a_drop_only_on_report, clock, reset, drop_out_ff != 32'd0, rep_ff)
   `TWAB_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
endmodule
